@@ hw/rtl/fwpm_pkg.sv @@
package fwpm_pkg;

  // Field widths fixed by the interface.
  localparam int FRAME_W   = 6;   // frame index
  localparam int CNT_W     = 7;   // frame count and window size
  localparam int MASK_W    = 64;  // eviction mask, one bit per frame index
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_FRAMES_DEF = 64;

  localparam logic [CNT_W-1:0] FRAME_COUNT_RESET = 7'd0;
  localparam logic [CNT_W-1:0] WINDOW_SIZE_RESET = 7'd20;

  typedef enum logic [1:0] {
    ST_UNLOADED = 2'd0,
    ST_READING  = 2'd1,
    ST_LOADED   = 2'd2,
    ST_BAD      = 2'd3
  } fstate_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 2'd0,
    OP_SEEK      = 2'd1,
    OP_ADVANCE   = 2'd2,
    OP_LOAD_DONE = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT = 1'b0,
    REG_WINDOW_SIZE = 1'b1
  } reg_idx_t;

  // Request from the sequencer to the residency table.
  typedef struct packed {
    logic               rd_en;
    logic [FRAME_W-1:0] rd_addr;
    logic               wr_en;
    logic [FRAME_W-1:0] wr_addr;
    fstate_t            wr_data;
  } mem_req_t;

endpackage

@@ hw/rtl/fwpm_state_mem.sv @@
module fwpm_state_mem #(
  parameter int DEPTH = fwpm_pkg::MAX_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fwpm_pkg::mem_req_t req,
  output fwpm_pkg::fstate_t  rd_state
);
  import fwpm_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fstate_t              mem [DEPTH];
  logic [DEPTH-1:0]     valid_r;
  fstate_t              rd_q_r;
  logic                 rd_v_r;

  logic [IDX_W-1:0] wa;
  logic [IDX_W-1:0] ra;

  assign wa = req.wr_addr[IDX_W-1:0];
  assign ra = req.rd_addr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wa] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[ra];
    end
  end

  // An entry that was never written reads as unloaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[wa] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_v_r <= valid_r[ra];
      end
    end
  end

  assign rd_state = rd_v_r ? rd_q_r : ST_UNLOADED;

endmodule

@@ hw/rtl/fwpm_ctrl.sv @@
module fwpm_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [fwpm_pkg::OP_W-1:0]      in_op,
  input  logic [fwpm_pkg::FRAME_W-1:0]   in_frame,
  input  logic                           in_loop_on_end,
  input  logic                           in_load_ok,
  input  logic [fwpm_pkg::CNT_W-1:0]     fc,
  input  logic [fwpm_pkg::CNT_W-1:0]     ws,
  output fwpm_pkg::mem_req_t             mreq,
  input  fwpm_pkg::fstate_t              mstate,
  output logic                           out_valid,
  output logic [fwpm_pkg::MASK_W-1:0]    out_evict_mask,
  output logic                           out_load_request,
  output logic [fwpm_pkg::FRAME_W-1:0]   out_load_frame,
  output logic [fwpm_pkg::FRAME_W-1:0]   out_position,
  output logic                           out_target_bad
);
  import fwpm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MV_RD  = 8'b0000_0010,
    S_MV_EV  = 8'b0000_0100,
    S_EVICT  = 8'b0000_1000,
    S_REDUCE = 8'b0001_0000,
    S_FWD    = 8'b0010_0000,
    S_BWD    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } seq_t;

  seq_t               state_r, state_nxt;
  logic [FRAME_W-1:0] cur_r, cur_nxt;
  logic [FRAME_W-1:0] wst_r, wst_nxt;
  logic               ok_r, ok_nxt;
  logic [CNT_W-1:0]   a_r, a_nxt;
  logic [FRAME_W-1:0] g_r, g_nxt;
  logic [7:0]         ff_r, ff_nxt;
  logic [FRAME_W-1:0] bf_r, bf_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [FRAME_W-1:0] pend_a_r, pend_a_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;
  logic               req_r, req_nxt;
  logic [FRAME_W-1:0] lf_r, lf_nxt;
  logic               bad_r, bad_nxt;

  op_t                op;
  logic               mv_go;
  logic               mv_valid;
  logic [FRAME_W-1:0] mv_tgt;
  logic [7:0]         win_end;
  logic [7:0]         wrap_pos;
  logic               ev_lo;
  logic               ev_hi;
  logic [FRAME_W-1:0] half_ws;
  logic [FRAME_W-1:0] bf_m1;
  fstate_t            new_st;

  assign op       = op_t'(in_op);
  assign win_end  = 8'(wst_r) + 8'(ws);
  assign half_ws  = ws[CNT_W-1:1];
  assign bf_m1    = bf_r - FRAME_W'(1);
  assign new_st   = (mstate == ST_UNLOADED) ? (ok_r ? ST_LOADED : ST_BAD) : mstate;

  // Frames below the window start stay only when they fall in the part of the
  // window that wraps past the last frame.
  assign wrap_pos = 8'(pend_a_r) + 8'(fc);
  assign ev_lo    = (8'(pend_a_r) < 8'(wst_r)) &&
                    !((wrap_pos >= 8'(wst_r)) && (wrap_pos < win_end));
  assign ev_hi    = 8'(pend_a_r) >= win_end;

  // Target of a seek or advance.
  always_comb begin
    mv_valid = 1'b0;
    mv_tgt   = in_frame;
    if (op == OP_SEEK) begin
      mv_valid = 1'b1;
    end else if (fc != '0) begin
      if (CNT_W'(cur_r) >= fc - CNT_W'(1)) begin
        mv_valid = in_loop_on_end;
        mv_tgt   = '0;
      end else begin
        mv_valid = 1'b1;
        mv_tgt   = cur_r + FRAME_W'(1);
      end
    end
    mv_go = mv_valid && (mv_tgt != cur_r) && (CNT_W'(mv_tgt) < fc);
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    wst_nxt    = wst_r;
    ok_nxt     = ok_r;
    a_nxt      = a_r;
    g_nxt      = g_r;
    ff_nxt     = ff_r;
    bf_nxt     = bf_r;
    pend_v_nxt = pend_v_r;
    pend_a_nxt = pend_a_r;
    mask_nxt   = mask_r;
    req_nxt    = req_r;
    lf_nxt     = lf_r;
    bad_nxt    = bad_r;
    mreq       = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mask_nxt   = '0;
          req_nxt    = 1'b0;
          lf_nxt     = '0;
          bad_nxt    = 1'b0;
          pend_v_nxt = 1'b0;
          state_nxt  = S_DONE;
          case (op)
            OP_TICK: begin
              g_nxt = cur_r;
              a_nxt = '0;
              if (fc > CNT_W'(1)) begin
                state_nxt = (ws < fc) ? S_EVICT : S_REDUCE;
              end
            end
            OP_SEEK, OP_ADVANCE: begin
              if (mv_go) begin
                cur_nxt = mv_tgt;
                ok_nxt  = in_load_ok;
                if (fc > CNT_W'(1)) begin
                  state_nxt = S_MV_RD;
                end
              end
            end
            OP_LOAD_DONE: begin
              if (CNT_W'(in_frame) < fc) begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = in_frame;
                mreq.wr_data = in_load_ok ? ST_LOADED : ST_BAD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_MV_RD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = cur_r;
        state_nxt    = S_MV_EV;
      end

      S_MV_EV: begin
        if (mstate == ST_UNLOADED) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = cur_r;
          mreq.wr_data = new_st;
        end
        if (new_st == ST_BAD) begin
          bad_nxt = 1'b1;
        end else begin
          wst_nxt = (cur_r >= half_ws) ? cur_r - half_ws : '0;
        end
        state_nxt = S_DONE;
      end

      // One entry read per cycle; the entry read in the previous cycle is
      // judged and written back while the next one is read.
      S_EVICT: begin
        if (pend_v_r && (mstate == ST_LOADED) && (ev_lo || ev_hi)) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = pend_a_r;
          mreq.wr_data = ST_UNLOADED;
          mask_nxt     = mask_r | (MASK_W'(1) << pend_a_r);
        end
        if (a_r < fc) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = a_r[FRAME_W-1:0];
          pend_v_nxt   = 1'b1;
          pend_a_nxt   = a_r[FRAME_W-1:0];
          a_nxt        = a_r + CNT_W'(1);
        end else begin
          pend_v_nxt = 1'b0;
          if (!pend_v_r) begin
            state_nxt = S_REDUCE;
          end
        end
      end

      // Bring the forward scan start into the frame range.
      S_REDUCE: begin
        if (CNT_W'(g_r) >= fc) begin
          g_nxt = g_r - fc[FRAME_W-1:0];
        end else begin
          ff_nxt    = 8'(cur_r);
          state_nxt = S_FWD;
        end
      end

      S_FWD, S_BWD: begin
        if (pend_v_r && (mstate != ST_LOADED)) begin
          pend_v_nxt = 1'b0;
          state_nxt  = S_DONE;
          if (mstate == ST_UNLOADED) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = pend_a_r;
            mreq.wr_data = ST_READING;
            req_nxt      = 1'b1;
            lf_nxt       = pend_a_r;
          end
        end else if (state_r == S_FWD) begin
          if (ff_r < win_end) begin
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = g_r;
            pend_v_nxt   = 1'b1;
            pend_a_nxt   = g_r;
            ff_nxt       = ff_r + 8'd1;
            g_nxt        = (CNT_W'(g_r) + CNT_W'(1) == fc) ? '0 : g_r + FRAME_W'(1);
          end else begin
            pend_v_nxt = 1'b0;
            if (!pend_v_r) begin
              bf_nxt    = cur_r;
              state_nxt = S_BWD;
            end
          end
        end else begin
          pend_v_nxt = 1'b0;
          if (bf_r > wst_r) begin
            bf_nxt = bf_m1;
            if (CNT_W'(bf_m1) < fc) begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = bf_m1;
              pend_v_nxt   = 1'b1;
              pend_a_nxt   = bf_m1;
            end
          end else if (!pend_v_r) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cur_r    <= '0;
      wst_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      wst_r    <= wst_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r     <= ok_nxt;
    a_r      <= a_nxt;
    g_r      <= g_nxt;
    ff_r     <= ff_nxt;
    bf_r     <= bf_nxt;
    pend_a_r <= pend_a_nxt;
    mask_r   <= mask_nxt;
    req_r    <= req_nxt;
    lf_r     <= lf_nxt;
    bad_r    <= bad_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_DONE);
  assign out_evict_mask   = mask_r;
  assign out_load_request = req_r;
  assign out_load_frame   = lf_r;
  assign out_position     = cur_r;
  assign out_target_bad   = bad_r;

endmodule

@@ hw/rtl/frame_window_prefetch_manager.sv @@
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+---------------------------------
// input     | in_op, in_frame, in_loop_on_end, in_load_ok    | taken when start=1 and busy=0
// result    | out_evict_mask, out_load_request,              | out_valid high for one cycle,
//           | out_load_frame, out_position, out_target_bad   | taken at the end of that cycle
// config    | cfg_index, cfg_wdata                           | written when cfg_valid=cfg_ready=1
//
// One item is in flight at a time; busy is high from the cycle after start until the
// result strobe has gone. A load-done item goes straight to the result, as does a seek or
// advance that does not move or that has at most one frame; any other move reads the table
// entry of the new frame, then settles an unloaded entry as loaded or bad and moves the
// window unless the frame is bad. A tick with at most one frame goes straight to the result;
// otherwise it runs an eviction pass (when the window is smaller than the frame count),
// subtracts the frame count until the current frame is in range, and runs the forward and
// backward prefetch scans, paced by the single read port of the table, one entry a cycle.
// Reset (rst_n low, synchronous) marks every table entry unloaded through per-entry valid
// bits and takes effect at once. The receiver cannot stall the result channel.
module frame_window_prefetch_manager #(
  parameter int MAX_FRAMES = fwpm_pkg::MAX_FRAMES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [fwpm_pkg::OP_W-1:0]         in_op,
  input  logic [fwpm_pkg::FRAME_W-1:0]      in_frame,
  input  logic                              in_loop_on_end,
  input  logic                              in_load_ok,
  output logic                              out_valid,
  output logic [fwpm_pkg::MASK_W-1:0]       out_evict_mask,
  output logic                              out_load_request,
  output logic [fwpm_pkg::FRAME_W-1:0]      out_load_frame,
  output logic [fwpm_pkg::FRAME_W-1:0]      out_position,
  output logic                              out_target_bad,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fwpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fwpm_pkg::CNT_W-1:0]        cfg_wdata
);
  import fwpm_pkg::*;

  logic [CNT_W-1:0] frame_count_r;
  logic [CNT_W-1:0] window_size_r;
  logic [CNT_W-1:0] fc_eff;
  mem_req_t         mreq;
  fstate_t          mstate;

  // The configuration registers are to be written only while the block is idle (the block
  // itself does not enforce this), so the write channel never needs to push back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RESET;
      window_size_r <= WINDOW_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_FRAME_COUNT: frame_count_r <= cfg_wdata;
        REG_WINDOW_SIZE: window_size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A frame count above the table depth behaves as the table depth.
  assign fc_eff = (frame_count_r > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : frame_count_r;

  fwpm_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_frame         (in_frame),
    .in_loop_on_end   (in_loop_on_end),
    .in_load_ok       (in_load_ok),
    .fc               (fc_eff),
    .ws               (window_size_r),
    .mreq             (mreq),
    .mstate           (mstate),
    .out_valid        (out_valid),
    .out_evict_mask   (out_evict_mask),
    .out_load_request (out_load_request),
    .out_load_frame   (out_load_frame),
    .out_position     (out_position),
    .out_target_bad   (out_target_bad)
  );

  // Residency table: one state per frame, read through a registered output.
  fwpm_state_mem #(
    .DEPTH (MAX_FRAMES)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mreq),
    .rd_state (mstate)
  );

endmodule

@@ hw/rtl/fwpm_checker.sv @@
module fwpm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [fwpm_pkg::MASK_W-1:0]       out_evict_mask,
  input logic                              out_load_request,
  input logic [fwpm_pkg::FRAME_W-1:0]      out_load_frame,
  input logic                              out_target_bad
);
  import fwpm_pkg::*;

  // Accepting an item makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // Every result is a single-cycle strobe and the block is idle right after it.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe not followed by idle");

  // A result is only shown while an item is in flight.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // Without a load request the requested frame reads zero.
  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_load_request) |-> (out_load_frame == '0))
    else $error("load frame set without a load request");

  // Evictions come only from ticks and a bad target only from moves.
  a_kind_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_target_bad) |-> ((out_evict_mask == '0) && !out_load_request))
    else $error("bad target reported together with tick results");

endmodule

bind frame_window_prefetch_manager fwpm_checker u_fwpm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_evict_mask   (out_evict_mask),
  .out_load_request (out_load_request),
  .out_load_frame   (out_load_frame),
  .out_target_bad   (out_target_bad)
);

@@ dv/frame_window_prefetch_manager_tb.sv @@
module frame_window_prefetch_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fwpm_pkg::*;

  // A tick may walk the whole table several times without a handshake; a quiet
  // stretch that reaches STALL_LIMIT means the block is stuck.
  localparam int STALL_LIMIT = 4000;

  // One result item as the block reports it.
  typedef struct packed {
    logic [MASK_W-1:0]  evict;
    logic               req;
    logic [FRAME_W-1:0] req_frame;
    logic [FRAME_W-1:0] pos;
    logic               bad;
  } step_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] in_op = '0;
  logic [FRAME_W-1:0] in_frame = '0;
  logic in_loop_on_end = 1'b0;
  logic in_load_ok = 1'b0;
  logic out_valid;
  logic [MASK_W-1:0] out_evict_mask;
  logic out_load_request;
  logic [FRAME_W-1:0] out_load_frame;
  logic [FRAME_W-1:0] out_position;
  logic out_target_bad;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  frame_window_prefetch_manager dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_frame         (in_frame),
    .in_loop_on_end   (in_loop_on_end),
    .in_load_ok       (in_load_ok),
    .out_valid        (out_valid),
    .out_evict_mask   (out_evict_mask),
    .out_load_request (out_load_request),
    .out_load_frame   (out_load_frame),
    .out_position     (out_position),
    .out_target_bad   (out_target_bad),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block's state, advanced once per accepted item.
  fstate_t          shadow_state [MAX_FRAMES_DEF];
  logic [FRAME_W-1:0] shadow_pos;
  logic [FRAME_W-1:0] shadow_win_start;
  logic [CNT_W-1:0]   shadow_frame_count;
  logic [CNT_W-1:0]   shadow_window_size;

  // Results the block still owes, oldest first.
  step_result_t pending_results [$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  // Tracks the level that start was last driven to, so that it is lowered
  // only once and never lowered and raised within one time step.
  bit start_hi = 1'b0;

  // Counts above the table size behave as a full table.
  function automatic int live_count();
    return (shadow_frame_count > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : int'(shadow_frame_count);
  endfunction

  // Seek or advance to a target frame. An unloaded target is loaded at once
  // with the given outcome; a bad target leaves the window where it was.
  task automatic move_position(input int tgt, input logic ok, output logic bad);
    int fc;
    int s;
    fc = live_count();
    bad = 1'b0;
    if (tgt == int'(shadow_pos) || tgt >= fc) return;
    shadow_pos = tgt[FRAME_W-1:0];
    if (fc <= 1) return;
    if (shadow_state[tgt] == ST_UNLOADED) begin
      if (ok) shadow_state[tgt] = ST_LOADED;
      else shadow_state[tgt] = ST_BAD;
    end
    if (shadow_state[tgt] == ST_BAD) begin
      bad = 1'b1;
      return;
    end
    s = int'(shadow_pos) - int'(shadow_window_size / 2);
    shadow_win_start = (s < 0) ? '0 : s[FRAME_W-1:0];
  endtask

  // Evict loaded frames outside a window smaller than the frame count, then pick at most
  // one frame to prefetch: forward from the current frame with wrap, then backward.
  task automatic scan_window(output logic [MASK_W-1:0] evict, output logic req,
                             output logic [FRAME_W-1:0] req_frame);
    int fc;
    int ws;
    int st;
    int a;
    int d;
    int ff;
    int g;
    int f;
    evict = '0;
    req = 1'b0;
    req_frame = '0;
    fc = live_count();
    ws = int'(shadow_window_size);
    st = int'(shadow_win_start);
    if (fc <= 1) return;
    if (ws < fc) begin
      for (a = 0; a < st && a < fc; a++) begin
        // Frames just below the start count as inside when the window wraps.
        d = a + fc - st;
        if (!(d >= 0 && d < ws) && shadow_state[a] == ST_LOADED) begin
          shadow_state[a] = ST_UNLOADED;
          evict[a] = 1'b1;
        end
      end
      for (a = st + ws; a < fc; a++) begin
        if (shadow_state[a] == ST_LOADED) begin
          shadow_state[a] = ST_UNLOADED;
          evict[a] = 1'b1;
        end
      end
    end
    for (ff = int'(shadow_pos); ff < st + ws; ff++) begin
      g = ff % fc;
      if (shadow_state[g] == ST_READING || shadow_state[g] == ST_BAD) return;
      if (shadow_state[g] == ST_UNLOADED) begin
        shadow_state[g] = ST_READING;
        req = 1'b1;
        req_frame = g[FRAME_W-1:0];
        return;
      end
    end
    for (f = int'(shadow_pos) - 1; f >= st; f--) begin
      if (f >= fc) continue;
      if (shadow_state[f] == ST_READING || shadow_state[f] == ST_BAD) return;
      if (shadow_state[f] == ST_UNLOADED) begin
        shadow_state[f] = ST_READING;
        req = 1'b1;
        req_frame = f[FRAME_W-1:0];
        return;
      end
    end
  endtask

  // Work out the result of one accepted item and advance the shadow state.
  task automatic advance_residency(input op_t op, input logic [FRAME_W-1:0] frame,
                                   input logic lp, input logic ok,
                                   output step_result_t r);
    int fc;
    logic bad;
    fc = live_count();
    r = '0;
    bad = 1'b0;
    case (op)
      OP_TICK: begin
        scan_window(r.evict, r.req, r.req_frame);
      end
      OP_SEEK: begin
        move_position(int'(frame), ok, bad);
      end
      OP_ADVANCE: begin
        if (fc != 0) begin
          if (int'(shadow_pos) >= fc - 1) begin
            if (lp) move_position(0, ok, bad);
          end else begin
            move_position(int'(shadow_pos) + 1, ok, bad);
          end
        end
      end
      default: begin
        if (int'(frame) < fc) begin
          if (ok) shadow_state[frame] = ST_LOADED;
          else shadow_state[frame] = ST_BAD;
        end
      end
    endcase
    r.bad = bad;
    r.pos = shadow_pos;
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Results cannot be held off, so every strobe is checked on the edge that
  // ends it against the oldest expectation.
  always @(posedge clk) begin
    step_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with no expectation waiting");
      end else begin
        exp_r = pending_results.pop_front();
        if (out_evict_mask !== exp_r.evict)
          report_mismatch($sformatf("evict_mask %h, expected %h", out_evict_mask, exp_r.evict));
        if (out_load_request !== exp_r.req)
          report_mismatch($sformatf("load_request %b, expected %b", out_load_request, exp_r.req));
        if (out_load_frame !== exp_r.req_frame)
          report_mismatch($sformatf("load_frame %0d, expected %0d", out_load_frame,
                                    exp_r.req_frame));
        if (out_position !== exp_r.pos)
          report_mismatch($sformatf("position %0d, expected %0d", out_position, exp_r.pos));
        if (out_target_bad !== exp_r.bad)
          report_mismatch($sformatf("target_bad %b, expected %b", out_target_bad, exp_r.bad));
      end
    end
  end

  // The watchdog restarts on any handshake: an item taken, a result, or a
  // register write. A long quiet stretch means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("frame_window_prefetch_manager regression: fail");
        $finish;
      end
    end
  end

  task automatic lower_start();
    if (start_hi) begin
      start <= 1'b0;
      start_hi = 1'b0;
    end
  endtask

  // Present one item and hold it until the block takes it. Start stays high
  // afterwards so that a following item can go out back to back.
  task automatic send_item(input op_t op, input logic [FRAME_W-1:0] frame,
                           input logic lp, input logic ok);
    step_result_t r;
    start <= 1'b1;
    start_hi = 1'b1;
    in_op <= op;
    in_frame <= frame;
    in_loop_on_end <= lp;
    in_load_ok <= ok;
    do @(posedge clk); while (busy);
    advance_residency(op, frame, lp, ok, r);
    pending_results.push_back(r);
  endtask

  task automatic hold_off(input int cycles);
    lower_start();
    repeat (cycles) @(posedge clk);
  endtask

  // Let the block finish everything it owes and go idle.
  task automatic wait_for_results();
    lower_start();
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Both registers are written back to back; only called while idle.
  task automatic write_config(input int fc, input int ws);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_COUNT;
    cfg_wdata <= fc[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    shadow_frame_count = fc[CNT_W-1:0];
    cfg_index <= REG_WINDOW_SIZE;
    cfg_wdata <= ws[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    shadow_window_size = ws[CNT_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // With the reset count of zero nothing can move, and with one frame a seek
  // moves the position but loads nothing and a tick does nothing.
  task automatic test_short_trajectory();
    send_item(OP_ADVANCE, 6'd0, 1'b1, 1'b1);
    send_item(OP_SEEK, 6'd5, 1'b0, 1'b1);
    send_item(OP_TICK, 6'd0, 1'b0, 1'b0);
    send_item(OP_LOAD_DONE, 6'd3, 1'b0, 1'b1);
    wait_for_results();
    write_config(8, 4);
    send_item(OP_SEEK, 6'd5, 1'b0, 1'b1);
    wait_for_results();
    // The table keeps its entries when the count shrinks.
    write_config(1, 4);
    send_item(OP_SEEK, 6'd0, 1'b1, 1'b0);
    send_item(OP_TICK, 6'd0, 1'b0, 1'b0);
    send_item(OP_ADVANCE, 6'd0, 1'b1, 1'b0);
    wait_for_results();
  endtask

  // Seeks, bad targets, eviction, the prefetch scans, load completion and
  // the end-of-trajectory behavior of advance.
  task automatic test_window_moves();
    write_config(12, 6);
    send_item(OP_SEEK, 6'd6, 1'b0, 1'b1);
    send_item(OP_SEEK, 6'd9, 1'b0, 1'b0);      // bad target, window stays
    send_item(OP_TICK, 6'd0, 1'b0, 1'b0);      // forward scan empty, backward scan requests 8
    send_item(OP_LOAD_DONE, 6'd9, 1'b0, 1'b1);
    send_item(OP_TICK, 6'd0, 1'b0, 1'b0);      // evicts 9, backward scan stops at frame 8
    send_item(OP_TICK, 6'd0, 1'b0, 1'b0);      // stops at the frame being read
    send_item(OP_SEEK, 6'd8, 1'b0, 1'b0);      // target still reading
    send_item(OP_ADVANCE, 6'd0, 1'b0, 1'b1);
    send_item(OP_SEEK, 6'd11, 1'b1, 1'b1);
    send_item(OP_ADVANCE, 6'd0, 1'b0, 1'b1);   // stays at the last frame
    send_item(OP_ADVANCE, 6'd0, 1'b1, 1'b1);   // wraps to frame zero
    send_item(OP_SEEK, 6'd20, 1'b0, 1'b1);     // beyond the count, ignored
    send_item(OP_LOAD_DONE, 6'd50, 1'b0, 1'b1);
    send_item(OP_TICK, 6'd0, 1'b0, 1'b0);
    wait_for_results();
  endtask

  // Register extremes: a count above the table size, window sizes of zero
  // and of the register's top value.
  task automatic test_register_extremes();
    write_config(127, 0);
    send_item(OP_SEEK, 6'd63, 1'b1, 1'b1);
    send_item(OP_TICK, 6'd0, 1'b0, 1'b0);      // every loaded frame leaves
    wait_for_results();
    write_config(64, 127);
    send_item(OP_TICK, 6'd0, 1'b0, 1'b0);
    send_item(OP_SEEK, 6'd0, 1'b0, 1'b1);
    send_item(OP_LOAD_DONE, 6'd63, 1'b0, 1'b0);
    send_item(OP_TICK, 6'd0, 1'b0, 1'b0);
    wait_for_results();
  endtask

  // Random traffic under one setting. Most items follow how the block is
  // used: ticks that raise prefetch requests, completions for the frames
  // being read, seeks and advances within the trajectory. The rest is noise.
  task automatic test_random_traffic(input int n_items, input int fc, input int ws,
                                     input bit gaps);
    int i;
    int roll;
    int fc_live;
    int reading_frames [$];
    logic [FRAME_W-1:0] fr;
    logic lp;
    logic ok;
    op_t op;
    bit gaps_now;
    write_config(fc, ws);
    fc_live = (fc > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : fc;
    gaps_now = 1'b0;
    for (i = 0; i < n_items; i++) begin
      // Gaps come and go in stretches, so some runs of items go back to back.
      if (i % 40 == 0) gaps_now = gaps && ($urandom_range(0, 2) != 0);
      if (gaps && i == n_items / 2) wait_for_results();
      if (gaps_now && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 17));
      roll = $urandom_range(0, 99);
      fr = FRAME_W'($urandom_range(0, 63));
      lp = 1'($urandom_range(0, 1));
      ok = ($urandom_range(0, 9) != 0);
      op = OP_TICK;
      if (roll >= 35 && roll < 60) begin
        reading_frames.delete();
        for (int k = 0; k < MAX_FRAMES_DEF; k++)
          if (shadow_state[k] == ST_READING) reading_frames.push_back(k);
        if (reading_frames.size() != 0) begin
          op = OP_LOAD_DONE;
          fr = FRAME_W'(reading_frames[$urandom_range(0, reading_frames.size() - 1)]);
        end
      end else if (roll >= 60 && roll < 72) begin
        op = OP_SEEK;
        if (fc_live > 0 && $urandom_range(0, 9) != 0)
          fr = FRAME_W'($urandom_range(0, fc_live - 1));
      end else if (roll >= 72 && roll < 87) begin
        op = OP_ADVANCE;
      end else if (roll >= 87) begin
        op = op_t'($urandom_range(0, 3));
        ok = 1'($urandom_range(0, 1));
      end
      send_item(op, fr, lp, ok);
    end
    wait_for_results();
  endtask

  initial begin
    for (int k = 0; k < MAX_FRAMES_DEF; k++) shadow_state[k] = ST_UNLOADED;
    shadow_pos = '0;
    shadow_win_start = '0;
    shadow_frame_count = FRAME_COUNT_RESET;
    shadow_window_size = WINDOW_SIZE_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_short_trajectory();
    test_window_moves();
    test_register_extremes();

    test_random_traffic(300, 64, 20, 1'b1);
    test_random_traffic(250, 16, 5, 1'b1);
    test_random_traffic(200, 127, 64, 1'b1);
    test_random_traffic(150, 40, 0, 1'b1);
    test_random_traffic(150, 2, 1, 1'b1);
    test_random_traffic(200, 33, 127, 1'b1);
    test_random_traffic(200, $urandom_range(0, 127), $urandom_range(0, 127), 1'b1);
    // The closing stretch inserts no gaps between items.
    test_random_traffic(250, 64, $urandom_range(1, 64), 1'b0);

    wait_for_results();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("frame_window_prefetch_manager regression: pass");
    end else begin
      $display("frame_window_prefetch_manager regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/fwpm_pkg.sv
hw/rtl/fwpm_state_mem.sv
hw/rtl/fwpm_ctrl.sv
hw/rtl/frame_window_prefetch_manager.sv
hw/rtl/fwpm_checker.sv
dv/frame_window_prefetch_manager_tb.sv
